// ===== hdl/fvc_pkg.sv =====
// Shared types, opcodes and constants of the flow vector cumulant block.
`default_nettype none

package fvc_pkg;

    // CORDIC rotation count and start value (Q2.30, gain compensated)
    localparam int ROT_STEPS = 16;
    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

    // Widths of the result fields
    localparam int MULT_W = 13;
    localparam int VAL_W  = 18;

    // Multiply program of the event close
    localparam logic [3:0] MOP_XX   = 4'd0;
    localparam logic [3:0] MOP_YY   = 4'd1;
    localparam logic [3:0] MOP_AA   = 4'd2;
    localparam logic [3:0] MOP_BB   = 4'd3;
    localparam logic [3:0] MOP_XY   = 4'd4;
    localparam logic [3:0] MOP_T1   = 4'd5;
    localparam logic [3:0] MOP_T2   = 4'd6;
    localparam logic [3:0] MOP_PP   = 4'd7;
    localparam logic [3:0] MOP_PM   = 4'd8;
    localparam logic [3:0] MOP_MM1  = 4'd9;
    localparam logic [3:0] MOP_M23  = 4'd10;
    localparam logic [3:0] MOP_DEN4 = 4'd11;
    localparam logic [3:0] MOP_K2   = 4'd12;
    localparam logic [3:0] MOP_LAST = MOP_K2;

    // Terms folded into the four-particle numerator
    localparam logic [1:0] SOP_R  = 2'd0;
    localparam logic [1:0] SOP_T  = 2'd1;
    localparam logic [1:0] SOP_PM = 2'd2;
    localparam logic [1:0] SOP_K2 = 2'd3;

    // Division program
    localparam logic [1:0] DOP_MC   = 2'd0;
    localparam logic [1:0] DOP_MS   = 2'd1;
    localparam logic [1:0] DOP_TWO  = 2'd2;
    localparam logic [1:0] DOP_FOUR = 2'd3;

    typedef struct packed {
        logic       in_ready;
        logic       load_item;
        logic       rot_step;
        logic [3:0] rot_idx;
        logic       acc_update;
        logic       mul_start;
        logic       mul_store;
        logic [3:0] mul_op;
        logic       sum_step;
        logic [1:0] sum_op;
        logic       div_start;
        logic       div_store;
        logic [1:0] div_op;
        logic       emit;
    } fvc_cmd_t;

    typedef struct packed {
        logic last_item;
        logic mul_done;
        logic div_done;
        logic out_free;
    } fvc_stat_t;

    // Arctangent of 2^-i as a fraction of a 32-bit turn
    function automatic logic signed [32:0] atan_turn(input logic [3:0] i);
        logic signed [32:0] v;
        unique case (i)
            4'd0:  v = 33'sd536870912;
            4'd1:  v = 33'sd316933406;
            4'd2:  v = 33'sd167458907;
            4'd3:  v = 33'sd85004756;
            4'd4:  v = 33'sd42667331;
            4'd5:  v = 33'sd21354465;
            4'd6:  v = 33'sd10679838;
            4'd7:  v = 33'sd5340245;
            4'd8:  v = 33'sd2670163;
            4'd9:  v = 33'sd1335087;
            4'd10: v = 33'sd667544;
            4'd11: v = 33'sd333772;
            4'd12: v = 33'sd166886;
            4'd13: v = 33'sd83443;
            4'd14: v = 33'sd41722;
            4'd15: v = 33'sd20861;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/flow_vector_cumulants.sv =====
// Top level: per-event Qn/Q2n flow vectors with two- and four-particle cumulants.
// Each particle is accepted, rotated through 16 CORDIC steps and accumulated;
// s_tready stays low from the accept until the controller is back in idle.
// Closing an event runs 13 products through one 32 x 32 multiplier and
// 4 divisions at one quotient bit a cycle.
// A finished result waits in the output register while the next event streams in.
// aresetn (synchronous, active low) clears the sums and sets the harmonic to 2.
`default_nettype none

module flow_vector_cumulants
    import fvc_pkg::*;
#(
    parameter int MAX_ITEMS  = 4096,
    parameter int ANGLE_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_data,     // harmonic_order
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,      // angle
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // multiplicity[12:0], mean_cos[30:13], mean_sin[48:31],
    // two_corr[66:49], four_corr[84:67], zero pad[87:85]
    output logic [87:0]      m_tdata,
    // mean_valid[0], two_valid[1], four_valid[2], overflow_seen[3]
    output logic [3:0]       m_tuser
);

    fvc_cmd_t  cmd;
    fvc_stat_t stat;

    assign cfg_ready = 1'b1;
    assign s_tready  = cmd.in_ready;

    fvc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .stat     (stat),
        .cmd      (cmd)
    );

    fvc_dp #(
        .MAX_ITEMS  (MAX_ITEMS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

// ===== hdl/fvc_mul.sv =====
// 64 x 64 unsigned multiplier built from four registered 32 x 32 partial products.
`default_nettype none

module fvc_mul (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start,
    input  wire logic [63:0]  op_a,
    input  wire logic [63:0]  op_b,
    output logic      [127:0] prod,
    output logic              done
);

    logic [63:0]  a_reg, b_reg;
    logic [127:0] acc_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   sh_reg;
    logic [2:0]   cnt_reg;
    logic         busy_reg, done_reg;
    logic [31:0]  pa, pb;
    logic [1:0]   sh;

    // Pick the partial product for this cycle
    always_comb begin
        unique case (cnt_reg[1:0])
            2'd0: begin pa = a_reg[31:0];  pb = b_reg[31:0];  sh = 2'd0; end
            2'd1: begin pa = a_reg[31:0];  pb = b_reg[63:32]; sh = 2'd1; end
            2'd2: begin pa = a_reg[63:32]; pb = b_reg[31:0];  sh = 2'd1; end
            2'd3: begin pa = a_reg[63:32]; pb = b_reg[63:32]; sh = 2'd2; end
        endcase
    end

    // Multiply, then add the registered partial product in the following cycle
    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= op_a;
            b_reg   <= op_b;
            acc_reg <= '0;
        end else if (busy_reg) begin
            if (cnt_reg != 3'd4) begin
                pp_reg <= 64'(pa) * 64'(pb);
                sh_reg <= sh;
            end
            if (cnt_reg != 3'd0) begin
                acc_reg <= acc_reg + (128'(pp_reg) << {sh_reg, 5'b0});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == 3'd4);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd4) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign prod = acc_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// ===== hdl/fvc_div.sv =====
// Restoring divider: rounded, saturated Q2.16 quotient of two 128-bit values.
`default_nettype none

module fvc_div
    import fvc_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    start,
    input  wire logic [127:0]            num,
    input  wire logic [127:0]            den,
    output logic signed [VAL_W-1:0]      quot,
    output logic                         done
);

    localparam logic [2:0] D_IDLE  = 3'd0;
    localparam logic [2:0] D_CHECK = 3'd1;
    localparam logic [2:0] D_LOOP  = 3'd2;
    localparam logic [2:0] D_ROUND = 3'd3;
    localparam logic [2:0] D_FIN   = 3'd4;

    logic [2:0]             ph_reg;
    logic [127:0]           rem_reg, den_reg;
    logic [146:0]           d_reg;
    logic [19:0]            q_reg;
    logic [4:0]             k_reg;
    logic                   neg_reg, done_reg;
    logic signed [VAL_W-1:0] quot_reg;
    logic                   ge;

    assign ge = rem_reg >= d_reg[127:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg   <= D_IDLE;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (ph_reg)
                D_IDLE: begin
                    if (start) begin
                        ph_reg <= D_CHECK;
                    end
                end
                D_CHECK: begin
                    ph_reg <= ge ? D_FIN : D_LOOP;
                end
                D_LOOP: begin
                    if (k_reg == 5'd0) begin
                        ph_reg <= D_ROUND;
                    end
                end
                D_ROUND: ph_reg <= D_FIN;
                D_FIN: begin
                    done_reg <= 1'b1;
                    ph_reg   <= D_IDLE;
                end
                default: ph_reg <= D_IDLE;
            endcase
        end
    end

    // Divide one quotient bit per cycle
    always_ff @(posedge aclk) begin
        unique case (ph_reg)
            D_IDLE: begin
                if (start) begin
                    neg_reg <= num[127];
                    rem_reg <= num[127] ? -num : num;
                    den_reg <= den;
                    d_reg   <= {19'd0, den} << 19;
                    q_reg   <= '0;
                end
            end
            D_CHECK: begin
                if (ge) begin
                    q_reg <= 20'd1 << 19;
                end else begin
                    d_reg <= d_reg >> 1;
                    k_reg <= 5'd18;
                end
            end
            D_LOOP: begin
                if (ge) begin
                    rem_reg <= rem_reg - d_reg[127:0];
                    q_reg   <= q_reg | (20'd1 << k_reg);
                end
                d_reg <= d_reg >> 1;
                k_reg <= k_reg - 5'd1;
            end
            D_ROUND: begin
                if ({rem_reg[126:0], 1'b0} >= den_reg) begin
                    q_reg <= q_reg + 20'd1;
                end
            end
            D_FIN: begin
                if (neg_reg) begin
                    quot_reg <= (q_reg >= 20'd131072) ? -18'sd131072 : VAL_W'(-q_reg);
                end else begin
                    quot_reg <= (q_reg > 20'd131071) ? 18'sd131071 : VAL_W'(q_reg);
                end
            end
            default: ;
        endcase
    end

    assign quot = quot_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// ===== hdl/fvc_ctrl.sv =====
// Controller: sequences item rotation, accumulation and the event-close program.
`default_nettype none

module fvc_ctrl
    import fvc_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    input  wire fvc_stat_t stat,
    output fvc_cmd_t       cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ROT   = 4'd1;
    localparam logic [3:0] S_ACC   = 4'd2;
    localparam logic [3:0] S_MGO   = 4'd3;
    localparam logic [3:0] S_MWAIT = 4'd4;
    localparam logic [3:0] S_SUM   = 4'd5;
    localparam logic [3:0] S_DGO   = 4'd6;
    localparam logic [3:0] S_DWAIT = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;

    logic [3:0] state_reg, state_next;
    logic [3:0] step_reg, step_next;

    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        cmd            = '0;
        cmd.rot_idx    = step_reg;
        cmd.mul_op     = step_reg;
        cmd.sum_op     = step_reg[1:0];
        cmd.div_op     = step_reg[1:0];
        unique case (state_reg)
            S_IDLE: begin
                cmd.in_ready  = 1'b1;
                cmd.load_item = s_tvalid;
                if (s_tvalid) begin
                    state_next = S_ROT;
                    step_next  = '0;
                end
            end
            S_ROT: begin
                cmd.rot_step = 1'b1;
                step_next    = step_reg + 4'd1;
                if (step_reg == 4'(ROT_STEPS - 1)) begin
                    state_next = S_ACC;
                end
            end
            S_ACC: begin
                cmd.acc_update = 1'b1;
                step_next      = '0;
                state_next     = stat.last_item ? S_MGO : S_IDLE;
            end
            S_MGO: begin
                cmd.mul_start = 1'b1;
                state_next    = S_MWAIT;
            end
            S_MWAIT: begin
                if (stat.mul_done) begin
                    cmd.mul_store = 1'b1;
                    if (step_reg == MOP_LAST) begin
                        step_next  = '0;
                        state_next = S_SUM;
                    end else begin
                        step_next  = step_reg + 4'd1;
                        state_next = S_MGO;
                    end
                end
            end
            S_SUM: begin
                cmd.sum_step = 1'b1;
                if (step_reg[1:0] == SOP_K2) begin
                    step_next  = '0;
                    state_next = S_DGO;
                end else begin
                    step_next = step_reg + 4'd1;
                end
            end
            S_DGO: begin
                cmd.div_start = 1'b1;
                state_next    = S_DWAIT;
            end
            S_DWAIT: begin
                if (stat.div_done) begin
                    cmd.div_store = 1'b1;
                    if (step_reg[1:0] == DOP_FOUR) begin
                        state_next = S_EMIT;
                    end else begin
                        step_next  = step_reg + 4'd1;
                        state_next = S_DGO;
                    end
                end
            end
            S_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/fvc_dp.sv =====
// Datapath: CORDIC lanes, flow vector sums, close-of-event arithmetic and result register.
`default_nettype none

module fvc_dp
    import fvc_pkg::*;
#(
    parameter int MAX_ITEMS  = 4096,
    parameter int ANGLE_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire fvc_cmd_t    cmd,
    output fvc_stat_t        stat,
    input  wire logic        cfg_valid,
    input  wire logic [2:0]  cfg_data,
    input  wire logic [15:0] s_tdata,
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [87:0]      m_tdata,
    output logic [3:0]       m_tuser
);

    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int AW = ANGLE_BITS;

    // Configuration and event state
    logic [2:0]  harm_reg;
    logic        last_reg;
    logic [31:0] qnr_reg, qni_reg, q2r_reg, q2i_reg;
    logic [CW-1:0] cnt_reg;
    logic        drop_reg;

    // CORDIC lanes: lane 0 at n*phi, lane 1 at 2n*phi
    logic signed [33:0] x_reg [2];
    logic signed [33:0] y_reg [2];
    logic signed [32:0] z_reg [2];
    logic [1:0]         quad_reg [2];

    logic [AW-1:0]      a_w;
    logic [AW+2:0]      hprod;
    logic [AW-1:0]      ph_w [2];
    logic [31:0]        p_w [2];
    logic [31:0]        qs_w [2];
    logic [31:0]        res_w [2];
    logic signed [33:0] sx_w [2];
    logic signed [33:0] sy_w [2];
    logic signed [16:0] cc_w [2];
    logic signed [16:0] ss_w [2];
    logic signed [16:0] c_w [2];
    logic signed [16:0] s_w [2];
    logic signed [32:0] at_w;

    // Round Q2.30 to Q1.15 and saturate
    function automatic logic signed [16:0] to_q115(input logic signed [33:0] v);
        logic signed [34:0] t;
        logic signed [19:0] r;
        logic signed [16:0] o;
        t = 35'(v) + 35'sd16384;
        r = 20'(t >>> 15);
        if (r > 20'sd32767) begin
            o = 17'sd32767;
        end else if (r < -20'sd32768) begin
            o = -17'sd32768;
        end else begin
            o = 17'(r);
        end
        return o;
    endfunction

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? -v : v;
    endfunction

    function automatic logic [63:0] mag64(input logic [63:0] v);
        return v[63] ? -v : v;
    endfunction

    // Phase of both lanes, quadrant split and per-step rotation terms
    assign a_w   = AW'(s_tdata);
    assign hprod = (AW+3)'(harm_reg) * (AW+3)'(a_w);
    assign ph_w[0] = hprod[AW-1:0];
    assign ph_w[1] = {hprod[AW-2:0], 1'b0};
    assign at_w  = atan_turn(cmd.rot_idx);

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            p_w[l]   = {ph_w[l], {(32-AW){1'b0}}};
            qs_w[l]  = p_w[l] + 32'h2000_0000;
            res_w[l] = p_w[l] - {qs_w[l][31:30], 30'd0};
            sx_w[l]  = x_reg[l] >>> cmd.rot_idx;
            sy_w[l]  = y_reg[l] >>> cmd.rot_idx;
            cc_w[l]  = to_q115(x_reg[l]);
            ss_w[l]  = to_q115(y_reg[l]);
            unique case (quad_reg[l])
                2'd0: begin c_w[l] = cc_w[l];  s_w[l] = ss_w[l];  end
                2'd1: begin c_w[l] = -ss_w[l]; s_w[l] = cc_w[l];  end
                2'd2: begin c_w[l] = -cc_w[l]; s_w[l] = -ss_w[l]; end
                2'd3: begin c_w[l] = ss_w[l];  s_w[l] = -cc_w[l]; end
            endcase
        end
    end

    // Load the item, then rotate both lanes one step per cycle
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            last_reg <= s_tlast;
            for (int l = 0; l < 2; l++) begin
                x_reg[l]    <= CORDIC_X0;
                y_reg[l]    <= '0;
                z_reg[l]    <= 33'(signed'(res_w[l]));
                quad_reg[l] <= qs_w[l][31:30];
            end
        end else if (cmd.rot_step) begin
            for (int l = 0; l < 2; l++) begin
                if (!z_reg[l][32]) begin
                    x_reg[l] <= x_reg[l] - sy_w[l];
                    y_reg[l] <= y_reg[l] + sx_w[l];
                    z_reg[l] <= z_reg[l] - at_w;
                end else begin
                    x_reg[l] <= x_reg[l] + sy_w[l];
                    y_reg[l] <= y_reg[l] - sx_w[l];
                    z_reg[l] <= z_reg[l] + at_w;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            harm_reg <= 3'd2;
        end else if (cfg_valid) begin
            harm_reg <= cfg_data;
        end
    end

    // Accumulate the flow vectors, or drop the item when the event is full; emit clears them
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qnr_reg  <= '0;
            qni_reg  <= '0;
            q2r_reg  <= '0;
            q2i_reg  <= '0;
            cnt_reg  <= '0;
            drop_reg <= 1'b0;
        end else if (cmd.emit) begin
            qnr_reg  <= '0;
            qni_reg  <= '0;
            q2r_reg  <= '0;
            q2i_reg  <= '0;
            cnt_reg  <= '0;
            drop_reg <= 1'b0;
        end else if (cmd.acc_update) begin
            if (cnt_reg != CW'(MAX_ITEMS)) begin
                qnr_reg <= qnr_reg + 32'(c_w[0]);
                qni_reg <= qni_reg + 32'(s_w[0]);
                q2r_reg <= q2r_reg + 32'(c_w[1]);
                q2i_reg <= q2i_reg + 32'(s_w[1]);
                cnt_reg <= cnt_reg + CW'(1);
            end else begin
                drop_reg <= 1'b1;
            end
        end
    end

    // Event-close operands
    logic [31:0]  mx, my, ma, mb;
    logic [63:0]  m64, mm1v, mm2v, mm3v;
    logic [63:0]  xx_reg, yy_reg, aa_reg, bb_reg, xy2_reg;
    logic [63:0]  mm1_reg, m23_reg, den4_reg, k2_reg;
    logic [127:0] t_reg, pm_reg, num4_reg;
    logic [63:0]  psum, dd, rsum;
    logic [63:0]  mul_a, mul_b;
    logic         mul_neg;
    logic [127:0] mul_p, mul_ps;
    logic         mul_done;
    logic [127:0] div_num, div_den;
    logic signed [VAL_W-1:0] div_q;
    logic         div_done;
    logic [127:0] term;
    logic signed [VAL_W-1:0] mc_reg, ms_reg, two_reg, four_reg;

    assign mx   = mag32(qnr_reg);
    assign my   = mag32(qni_reg);
    assign ma   = mag32(q2r_reg);
    assign mb   = mag32(q2i_reg);
    assign m64  = 64'(cnt_reg);
    assign mm1v = m64 - 64'd1;
    assign mm2v = m64 - 64'd2;
    assign mm3v = m64 - 64'd3;
    assign psum = xx_reg + yy_reg;
    assign dd   = xx_reg - yy_reg;
    assign rsum = aa_reg + bb_reg;

    // Multiply operand selection
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        unique case (cmd.mul_op)
            MOP_XX:   begin mul_a = 64'(mx); mul_b = 64'(mx); end
            MOP_YY:   begin mul_a = 64'(my); mul_b = 64'(my); end
            MOP_AA:   begin mul_a = 64'(ma); mul_b = 64'(ma); end
            MOP_BB:   begin mul_a = 64'(mb); mul_b = 64'(mb); end
            MOP_XY:   begin
                mul_a   = 64'(mx);
                mul_b   = 64'(my);
                mul_neg = qnr_reg[31] ^ qni_reg[31];
            end
            MOP_T1:   begin
                mul_a   = 64'(ma);
                mul_b   = mag64(dd);
                mul_neg = q2r_reg[31] ^ dd[63];
            end
            MOP_T2:   begin
                mul_a   = 64'(mb);
                mul_b   = mag64(xy2_reg);
                mul_neg = q2i_reg[31] ^ xy2_reg[63];
            end
            MOP_PP:   begin mul_a = psum;    mul_b = psum; end
            MOP_PM:   begin mul_a = psum;    mul_b = mm2v; end
            MOP_MM1:  begin mul_a = m64;     mul_b = mm1v; end
            MOP_M23:  begin mul_a = mm2v;    mul_b = mm3v; end
            MOP_DEN4: begin mul_a = mm1_reg; mul_b = m23_reg; end
            MOP_K2:   begin mul_a = m64;     mul_b = mm3v; end
            default:  ;
        endcase
    end

    assign mul_ps = mul_neg ? -mul_p : mul_p;

    fvc_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .prod    (mul_p),
        .done    (mul_done)
    );

    // Numerator term for each fold step
    always_comb begin
        unique case (cmd.sum_op)
            SOP_R:  term = 128'(rsum) << 30;
            SOP_T:  term = t_reg << 16;
            SOP_PM: term = pm_reg << 32;
            SOP_K2: term = 128'(k2_reg) << 60;
        endcase
    end

    // Store products and fold the four-particle numerator
    always_ff @(posedge aclk) begin
        if (cmd.mul_store) begin
            unique case (cmd.mul_op)
                MOP_XX:   xx_reg   <= mul_p[63:0];
                MOP_YY:   yy_reg   <= mul_p[63:0];
                MOP_AA:   aa_reg   <= mul_p[63:0];
                MOP_BB:   bb_reg   <= mul_p[63:0];
                MOP_XY:   xy2_reg  <= {mul_ps[62:0], 1'b0};
                MOP_T1:   t_reg    <= mul_ps;
                MOP_T2:   t_reg    <= t_reg + mul_ps;
                MOP_PP:   num4_reg <= mul_p;
                MOP_PM:   pm_reg   <= mul_p;
                MOP_MM1:  mm1_reg  <= mul_p[63:0];
                MOP_M23:  m23_reg  <= mul_p[63:0];
                MOP_DEN4: den4_reg <= mul_p[63:0];
                MOP_K2:   k2_reg   <= {mul_p[62:0], 1'b0};
                default:  ;
            endcase
        end else if (cmd.sum_step) begin
            if (cmd.sum_op == SOP_T || cmd.sum_op == SOP_PM) begin
                num4_reg <= num4_reg - term;
            end else begin
                num4_reg <= num4_reg + term;
            end
        end
    end

    // Division operand selection
    always_comb begin
        unique case (cmd.div_op)
            DOP_MC: begin
                div_num = {{95{qnr_reg[31]}}, qnr_reg, 1'b0};
                div_den = 128'(m64);
            end
            DOP_MS: begin
                div_num = {{95{qni_reg[31]}}, qni_reg, 1'b0};
                div_den = 128'(m64);
            end
            DOP_TWO: begin
                div_num = 128'(psum) - (128'(m64) << 30);
                div_den = 128'(mm1_reg) << 14;
            end
            DOP_FOUR: begin
                div_num = num4_reg;
                div_den = 128'(den4_reg) << 44;
            end
        endcase
    end

    fvc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .quot    (div_q),
        .done    (div_done)
    );

    always_ff @(posedge aclk) begin
        if (cmd.div_store) begin
            unique case (cmd.div_op)
                DOP_MC:   mc_reg   <= div_q;
                DOP_MS:   ms_reg   <= div_q;
                DOP_TWO:  two_reg  <= div_q;
                DOP_FOUR: four_reg <= div_q;
            endcase
        end
    end

    // Result register: load on emit, release when the request is taken
    logic              m_valid_reg;
    logic [87:0]       m_data_reg;
    logic [3:0]        m_user_reg;
    logic              mv_w, tv_w, fv_w;

    assign mv_w = cnt_reg != '0;
    assign tv_w = cnt_reg >= CW'(2);
    assign fv_w = cnt_reg >= CW'(4);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_data_reg <= {3'd0,
                           fv_w ? four_reg : '0,
                           tv_w ? two_reg  : '0,
                           mv_w ? ms_reg   : '0,
                           mv_w ? mc_reg   : '0,
                           MULT_W'(cnt_reg)};
            m_user_reg <= {drop_reg, fv_w, tv_w, mv_w};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    assign stat.last_item = last_reg;
    assign stat.mul_done  = mul_done;
    assign stat.div_done  = div_done;
    assign stat.out_free  = !m_valid_reg || m_tready;

    // Checks on the event bookkeeping
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid_reg || m_tready))
        else $error("result loaded over an untaken request");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(MAX_ITEMS))
        else $error("multiplicity beyond its limit");

    a_emit_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> (cnt_reg == '0 && !drop_reg && qnr_reg == '0))
        else $error("event state not cleared after emit");

    a_full_drops: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.acc_update && cnt_reg == CW'(MAX_ITEMS)) |=> drop_reg)
        else $error("dropped item not flagged");

endmodule

`default_nettype wire

// ===== dv/tb_flow_vector_cumulants.sv =====
// Testbench of flow_vector_cumulants: random and directed particle events checked against a predictor.
`timescale 1ns / 1ps

module tb_flow_vector_cumulants;
    import fvc_pkg::*;

    localparam int MAXN = 4096;

    typedef struct packed {
        logic [15:0] angle;
        logic        last;
    } particle_t;

    typedef struct packed {
        logic [12:0] mult;
        logic [17:0] mcos;
        logic [17:0] msin;
        logic [17:0] two;
        logic [17:0] four;
        logic [3:0]  flags;
    } event_result_t;

    typedef struct {
        bit        is_cfg;
        bit        drain;
        logic [2:0] hv;
        particle_t p;
    } request_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [2:0] cfg_data = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [15:0] s_tdata = 0;
    logic s_tlast = 0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [87:0] m_tdata;
    logic [3:0] m_tuser;

    flow_vector_cumulants dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #2 aclk = ~aclk;

    // Predictor state
    logic [2:0] harm;
    longint qx, qy, q2x, q2y;
    int unsigned pcount;
    bit dropped;

    request_t pending[$];
    event_result_t expected_results[$];
    int mismatches = 0;
    longint cycles = 0;
    bit calm = 0;
    bit stim_done = 0;

    localparam longint ATAN[16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
        21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861};

    function automatic int sat_q115(longint v);
        longint r;
        r = (v + 16384) >>> 15;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return int'(r);
    endfunction

    // CORDIC sine/cosine of a 16-bit phase, quadrant folded
    task automatic sincos(input logic [15:0] ph, output int c, output int s);
        logic [31:0] p, res;
        logic [1:0] quad;
        longint x, y, z, dx, dy;
        int cc, ss;
        p = {ph, 16'h0};
        quad = (p + 32'h2000_0000) >> 30;
        res = p - ({30'd0, quad} << 30);
        z = longint'(signed'(res));
        x = 652032874;
        y = 0;
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN[i];
            end else begin
                x += dx; y -= dy; z += ATAN[i];
            end
        end
        cc = sat_q115(x);
        ss = sat_q115(y);
        case (quad)
            2'd0: begin c = cc;  s = ss;  end
            2'd1: begin c = -ss; s = cc;  end
            2'd2: begin c = -cc; s = -ss; end
            default: begin c = ss; s = -cc; end
        endcase
    endtask

    // Rounded quotient, halves away from zero, saturated to Q2.16
    function automatic logic [17:0] div_q216(logic signed [255:0] num, logic signed [255:0] den);
        logic signed [255:0] a, q, r;
        bit neg;
        neg = num < 0;
        a = neg ? -num : num;
        q = a / den;
        r = a - q * den;
        if (2 * r >= den) q = q + 1;
        if (neg) q = -q;
        if (q > 131071) q = 131071;
        if (q < -131072) q = -131072;
        return q[17:0];
    endfunction

    task automatic predict_particle(input particle_t p);
        int c, s;
        logic signed [255:0] X, Y, A, B, M, P, R, T, num;
        event_result_t e;
        if (pcount < MAXN) begin
            sincos(16'(harm * p.angle), c, s);
            qx += c; qy += s;
            sincos(16'(2 * harm * p.angle), c, s);
            q2x += c; q2y += s;
            pcount++;
        end else begin
            dropped = 1;
        end
        if (!p.last) return;
        X = qx; Y = qy; A = q2x; B = q2y; M = pcount;
        e = '0;
        e.mult = pcount[12:0];
        if (pcount >= 1) begin
            e.mcos = div_q216(X * 2, M);
            e.msin = div_q216(Y * 2, M);
        end
        P = X * X + Y * Y;
        if (pcount >= 2)
            e.two = div_q216(P - (M <<< 30), (M * (M - 1)) <<< 14);
        if (pcount >= 4) begin
            R = A * A + B * B;
            T = A * (X * X - Y * Y) + B * X * Y * 2;
            num = P * P + (R <<< 30) - (T <<< 16) - ((P * (M - 2)) <<< 32)
                + ((2 * M * (M - 3)) <<< 60);
            e.four = div_q216(num, (M * (M - 1) * (M - 2) * (M - 3)) <<< 44);
        end
        e.flags = {dropped, pcount >= 4, pcount >= 2, pcount >= 1};
        expected_results.push_back(e);
        qx = 0; qy = 0; q2x = 0; q2y = 0; pcount = 0; dropped = 0;
    endtask

    function automatic bit idle_now();
        return !calm && ($urandom_range(99) < 7);
    endfunction

    // Driver: particles and register writes from the pending queue
    request_t cur;
    bit have = 0;
    int drain_wait = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) predict_particle(cur.p);
            if (cfg_valid && cfg_ready) harm = cfg_data;
            if ((s_tvalid && s_tready) || (cfg_valid && cfg_ready)) have = 0;
            if (!have && pending.size() > 0 && !idle_now()) begin
                if (pending[0].is_cfg || pending[0].drain) begin
                    // hold until every result is out and the close pipeline has settled
                    if (expected_results.size() == 0) drain_wait++;
                    else drain_wait = 0;
                    if (drain_wait > 400) begin
                        cur = pending.pop_front();
                        have = !cur.drain;
                        drain_wait = 0;
                    end
                end else begin
                    cur = pending.pop_front();
                    have = 1;
                end
            end
            s_tvalid <= have && !cur.is_cfg;
            cfg_valid <= have && cur.is_cfg;
            s_tdata <= cur.p.angle;
            s_tlast <= cur.p.last;
            cfg_data <= cur.hv;
            if (!have && pending.size() == 0) stim_done <= 1;
        end
    end

    // Monitor: compare each result with the oldest expectation
    always @(posedge aclk) begin
        event_result_t got, exp_r;
        cycles++;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = {m_tdata[12:0], m_tdata[30:13], m_tdata[48:31], m_tdata[66:49],
                       m_tdata[84:67], m_tuser};
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", got);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: M exp %0d got %0d | cos %h/%h sin %h/%h two %h/%h four %h/%h flags %b/%b",
                                exp_r.mult, got.mult, exp_r.mcos, got.mcos, exp_r.msin, got.msin,
                                exp_r.two, got.two, exp_r.four, got.four, exp_r.flags, got.flags);
                    end
                end
            end
            m_tready <= !idle_now();
        end
    end

    task automatic add_cfg(input logic [2:0] v);
        request_t r;
        r.is_cfg = 1; r.drain = 0; r.hv = v; r.p = '0;
        pending.push_back(r);
    endtask

    task automatic add_particle(input logic [15:0] a, input logic l);
        request_t r;
        r.is_cfg = 0; r.drain = 0; r.hv = 0; r.p = {a, l};
        pending.push_back(r);
    endtask

    task automatic add_event(input int n);
        for (int i = 0; i < n; i++) begin
            logic [15:0] a;
            case ($urandom_range(9))
                0: a = 16'h0000;
                1: a = 16'hFFFF;
                2: a = 16'(16384 * $urandom_range(3));
                default: a = 16'($urandom);
            endcase
            add_particle(a, i == n - 1);
        end
    endtask

    initial begin
        int sent;
        request_t d;
        harm = 2; qx = 0; qy = 0; q2x = 0; q2y = 0; pcount = 0; dropped = 0;
        // directed: single, pair, triple, quad and five-particle events and the edge angles
        add_particle(16'h0000, 1);
        add_particle(16'hFFFF, 0); add_particle(16'h8000, 1);
        add_particle(16'h2000, 0); add_particle(16'h4000, 0); add_particle(16'hA5A5, 1);
        add_particle(16'h0000, 0); add_particle(16'h0000, 0);
        add_particle(16'h0000, 0); add_particle(16'h0000, 1);
        add_particle(16'h1000, 0); add_particle(16'h5000, 0);
        add_particle(16'h9000, 0); add_particle(16'hD000, 0); add_particle(16'h5A5A, 1);
        add_cfg(3'd7); add_event(5);
        add_cfg(3'd0); add_event(4);
        add_cfg(3'd1); add_event(6);
        // sender pause until everything is out
        d.is_cfg = 0; d.drain = 1; d.hv = 0; d.p = '0;
        pending.push_back(d);
        sent = 40;
        while (sent < 1900) begin
            int n;
            if ($urandom_range(5) == 0) add_cfg(3'($urandom_range(7)));
            n = ($urandom_range(7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 30);
            add_event(n);
            sent += n;
        end
        add_event(4);
        repeat (6) @(posedge aclk);
        aresetn <= 1;
    end

    // Calm stretch with no idling on either side
    always @(posedge aclk) calm <= (cycles > 3000 && cycles < 15000);

    initial begin
        wait (stim_done);
        wait (expected_results.size() == 0);
        repeat (500) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        wait (cycles > 3000000);
        $display("status: fail");
        $finish;
    end

endmodule
